// ===== hdl/stni_pkg.sv =====
// Shared types and constants for the sign-threshold network iteration block.
// Used by every module of the block and by its port checker.
`default_nettype none

package stni_pkg;

  localparam int IN_W     = 32;
  localparam int OUT_W    = 8;
  localparam int MODE_W   = 2;
  localparam int GENE_W   = 6;
  localparam int WEIGHT_W = 16;
  localparam int TRIT_W   = 2;
  localparam int STEP_W   = 16;

  localparam logic [STEP_W-1:0] STEP_RESET = 16'd20;

  // Bit positions of the input fields inside in_tdata.
  localparam int MODE_LSB   = 0;
  localparam int ROW_LSB    = MODE_LSB + MODE_W;
  localparam int COL_LSB    = ROW_LSB + GENE_W;
  localparam int WEIGHT_LSB = COL_LSB + GENE_W;
  localparam int INIT_LSB   = WEIGHT_LSB + WEIGHT_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_WEIGHT = 2'd0,
    MODE_INIT   = 2'd1,
    MODE_RUN    = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_HOLD
  } seq_state_t;

  // Regions of the state memory: the initial vector and two ping-pong banks.
  typedef logic [1:0] rgn_t;
  localparam rgn_t RGN_INIT = 2'd0;
  localparam rgn_t RGN_A    = 2'd1;
  localparam rgn_t RGN_B    = 2'd2;

  typedef logic [TRIT_W-1:0] trit_t;
  localparam trit_t TRIT_ZERO = 2'b00;
  localparam trit_t TRIT_POS  = 2'b01;
  localparam trit_t TRIT_NEG  = 2'b11;

  // Control that travels with a weight/state read into the accumulate stage.
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } mac_ctl_t;

  // The unused pattern 2'b10 saturates to -1.
  function automatic trit_t trit_sat(input logic [TRIT_W-1:0] v);
    trit_t t;
    case (v) inside
      2'b00:        t = TRIT_ZERO;
      2'b01:        t = TRIT_POS;
      2'b10, 2'b11: t = TRIT_NEG;
      default:      t = TRIT_ZERO;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/sign_threshold_network_iteration.sv =====
// Sign-threshold gene network iteration. Input beats either load one weight
// W(i,j) or one initial state trit, or start a run. A run applies step_count
// synchronous updates, each reading all GENES*GENES weights (one weight read
// per cycle from the weight memory), then emits GENES result beats, each
// passing through the state memory read and the output register.
// No input beat is taken while a run is in progress. The initial vector reads
// as zero until written; weights must be written before a run uses them.
`default_nettype none

module sign_threshold_network_iteration
  import stni_pkg::*;
#(
  parameter int GENES = 16
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  cfg_wr_en,
  input  wire  [STEP_W-1:0]    cfg_wr_data,  // step_count
  input  wire                  in_tvalid,
  output logic                 in_tready,
  // mode[1:0], row_index[7:2], col_index[13:8], weight[29:14], init_value[31:30]
  input  wire  [IN_W-1:0]      in_tdata,
  output logic                 out_tvalid,
  input  wire                  out_tready,
  // gene_index[5:0], final_value[7:6]
  output logic [OUT_W-1:0]     out_tdata,
  output logic                 out_tlast
);

  localparam int IDX_W = $clog2(GENES);

  logic                w_wr_en;
  logic [2*IDX_W-1:0]  w_wr_addr;
  logic [WEIGHT_W-1:0] w_wr_data;
  logic                w_rd_en;
  logic [2*IDX_W-1:0]  w_rd_addr;
  logic [WEIGHT_W-1:0] w_rd_data;
  logic                s_wr_en;
  rgn_t                s_wr_rgn;
  logic [IDX_W-1:0]    s_wr_idx;
  trit_t               s_wr_data;
  logic                s_rd_en;
  rgn_t                s_rd_rgn;
  logic [IDX_W-1:0]    s_rd_idx;
  trit_t               s_rd_data;
  mac_ctl_t            mac_ctl;
  logic                mac_res_vld;
  trit_t               mac_res_trit;

  stni_seq #(.GENES(GENES), .IDX_W(IDX_W)) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast),
    .w_wr_en      (w_wr_en),
    .w_wr_addr    (w_wr_addr),
    .w_wr_data    (w_wr_data),
    .w_rd_en      (w_rd_en),
    .w_rd_addr    (w_rd_addr),
    .s_wr_en      (s_wr_en),
    .s_wr_rgn     (s_wr_rgn),
    .s_wr_idx     (s_wr_idx),
    .s_wr_data    (s_wr_data),
    .s_rd_en      (s_rd_en),
    .s_rd_rgn     (s_rd_rgn),
    .s_rd_idx     (s_rd_idx),
    .s_rd_data    (s_rd_data),
    .mac_ctl      (mac_ctl),
    .mac_res_vld  (mac_res_vld),
    .mac_res_trit (mac_res_trit)
  );

  stni_wmem #(.IDX_W(IDX_W)) u_wmem (
    .clk     (clk),
    .wr_en   (w_wr_en),
    .wr_addr (w_wr_addr),
    .wr_data (w_wr_data),
    .rd_en   (w_rd_en),
    .rd_addr (w_rd_addr),
    .rd_data (w_rd_data)
  );

  stni_smem #(.GENES(GENES), .IDX_W(IDX_W)) u_smem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (s_wr_en),
    .wr_rgn  (s_wr_rgn),
    .wr_idx  (s_wr_idx),
    .wr_data (s_wr_data),
    .rd_en   (s_rd_en),
    .rd_rgn  (s_rd_rgn),
    .rd_idx  (s_rd_idx),
    .rd_data (s_rd_data)
  );

  stni_mac #(.IDX_W(IDX_W)) u_mac (
    .clk      (clk),
    .ctl      (mac_ctl),
    .weight   (w_rd_data),
    .src      (s_rd_data),
    .res_vld  (mac_res_vld),
    .res_trit (mac_res_trit)
  );

endmodule

`default_nettype wire

// ===== hdl/stni_wmem.sv =====
// Weight memory: one write port, one read port with a registered read.
// Depends on stni_pkg for the weight width.
`default_nettype none

module stni_wmem
  import stni_pkg::*;
#(
  parameter int IDX_W = 4
) (
  input  wire                        clk,
  input  wire                        wr_en,
  input  wire  [2*IDX_W-1:0]         wr_addr,
  input  wire  [WEIGHT_W-1:0]        wr_data,
  input  wire                        rd_en,
  input  wire  [2*IDX_W-1:0]         rd_addr,
  output logic [WEIGHT_W-1:0]        rd_data
);

  localparam int DEPTH = 1 << (2 * IDX_W);

  logic [WEIGHT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/stni_smem.sv =====
// State memory: initial vector plus two ping-pong banks, registered read.
// Entries of the initial region read as zero until written. Depends on stni_pkg.
`default_nettype none

module stni_smem
  import stni_pkg::*;
#(
  parameter int GENES = 16,
  parameter int IDX_W = 4
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              wr_en,
  input  wire  rgn_t       wr_rgn,
  input  wire  [IDX_W-1:0] wr_idx,
  input  wire  trit_t      wr_data,
  input  wire              rd_en,
  input  wire  rgn_t       rd_rgn,
  input  wire  [IDX_W-1:0] rd_idx,
  output trit_t            rd_data
);

  localparam int DEPTH = 3 << IDX_W;

  trit_t              mem [DEPTH];
  trit_t              mem_q_r;
  logic               rd_ok_r;
  logic [GENES-1:0]   init_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[{wr_rgn, wr_idx}] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q_r <= mem[{rd_rgn, rd_idx}];
      rd_ok_r <= (rd_rgn != RGN_INIT) || init_vld_r[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_vld_r <= '0;
    end else if (wr_en && (wr_rgn == RGN_INIT)) begin
      init_vld_r[wr_idx] <= 1'b1;
    end
  end

  assign rd_data = rd_ok_r ? mem_q_r : TRIT_ZERO;

endmodule

`default_nettype wire

// ===== hdl/stni_mac.sv =====
// Accumulate stage: adds or subtracts one weight per cycle by the source trit
// and gives the sign of the column sum on its last term. Depends on stni_pkg.
`default_nettype none

module stni_mac
  import stni_pkg::*;
#(
  parameter int IDX_W = 4
) (
  input  wire                 clk,
  input  wire  mac_ctl_t      ctl,
  input  wire  [WEIGHT_W-1:0] weight,
  input  wire  trit_t         src,
  output logic                res_vld,
  output trit_t               res_trit
);

  // Up to 2**IDX_W terms of 16 bits, plus one bit of sign headroom.
  localparam int ACC_W = WEIGHT_W + IDX_W + 1;

  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_nxt;
  logic signed [ACC_W-1:0] wext;
  logic signed [ACC_W-1:0] term;

  always_comb begin
    wext = {{(ACC_W-WEIGHT_W){weight[WEIGHT_W-1]}}, weight};
    case (src)
      TRIT_POS: term = wext;
      TRIT_NEG: term = -wext;
      default:  term = '0;
    endcase
    acc_nxt = (ctl.first ? '0 : acc_r) + term;
  end

  always_ff @(posedge clk) begin
    if (ctl.vld) begin
      acc_r <= acc_nxt;
    end
  end

  assign res_vld  = ctl.vld && ctl.last;
  assign res_trit = (acc_nxt > 0) ? TRIT_POS : ((acc_nxt < 0) ? TRIT_NEG : TRIT_ZERO);

endmodule

`default_nettype wire

// ===== hdl/stni_seq.sv =====
// Sequencer: input decode, step/column/row counters, memory addressing,
// ping-pong bank choice and the result register. Depends on stni_pkg.
`default_nettype none

module stni_seq
  import stni_pkg::*;
#(
  parameter int GENES = 16,
  parameter int IDX_W = 4
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  cfg_wr_en,
  input  wire  [STEP_W-1:0]    cfg_wr_data,
  input  wire                  in_tvalid,
  output logic                 in_tready,
  input  wire  [IN_W-1:0]      in_tdata,
  output logic                 out_tvalid,
  input  wire                  out_tready,
  output logic [OUT_W-1:0]     out_tdata,
  output logic                 out_tlast,
  output logic                 w_wr_en,
  output logic [2*IDX_W-1:0]   w_wr_addr,
  output logic [WEIGHT_W-1:0]  w_wr_data,
  output logic                 w_rd_en,
  output logic [2*IDX_W-1:0]   w_rd_addr,
  output logic                 s_wr_en,
  output rgn_t                 s_wr_rgn,
  output logic [IDX_W-1:0]     s_wr_idx,
  output trit_t                s_wr_data,
  output logic                 s_rd_en,
  output rgn_t                 s_rd_rgn,
  output logic [IDX_W-1:0]     s_rd_idx,
  input  wire  trit_t          s_rd_data,
  output mac_ctl_t             mac_ctl,
  input  wire                  mac_res_vld,
  input  wire  trit_t          mac_res_trit
);

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(GENES - 1);
  localparam logic [GENE_W:0]  GENES_X  = (GENE_W + 1)'(GENES);

  seq_state_t         st_r, st_nxt;
  logic [STEP_W-1:0]  step_cnt_r;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [IDX_W-1:0]   i_r, i_nxt;
  logic [IDX_W-1:0]   j_r, j_nxt;
  logic [IDX_W-1:0]   k_r, k_nxt;
  rgn_t               fin_rgn_r, fin_rgn_nxt;
  mac_ctl_t           ctl_r, ctl_nxt;
  logic [IDX_W-1:0]   j_d_r;
  rgn_t               dest_d_r;
  trit_t              out_trit_r;

  logic               in_acc;
  mode_t              in_mode;
  logic [GENE_W-1:0]  in_row;
  logic [GENE_W-1:0]  in_col;
  logic               row_ok;
  logic               col_ok;
  rgn_t               src_rgn;
  rgn_t               dest_rgn;
  logic               step_done;
  logic               last_step;

  assign in_mode = mode_t'(in_tdata[MODE_LSB +: MODE_W]);
  assign in_row  = in_tdata[ROW_LSB +: GENE_W];
  assign in_col  = in_tdata[COL_LSB +: GENE_W];
  assign row_ok  = {1'b0, in_row} < GENES_X;
  assign col_ok  = {1'b0, in_col} < GENES_X;
  assign in_acc  = in_tvalid && in_tready;

  // Step 0 reads the initial vector; later steps alternate between the banks.
  assign src_rgn   = (step_r == '0) ? RGN_INIT : (step_r[0] ? RGN_A : RGN_B);
  assign dest_rgn  = step_r[0] ? RGN_B : RGN_A;
  assign step_done = (i_r == IDX_LAST) && (j_r == IDX_LAST);
  assign last_step = ({1'b0, step_r} + 1'b1) == {1'b0, step_cnt_r};

  // Next state.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: begin
        if (in_acc && (in_mode == MODE_RUN)) begin
          st_nxt = (step_cnt_r == '0) ? ST_EMIT_RD : ST_STEP;
        end
      end
      ST_STEP: begin
        if (step_done && last_step) begin
          st_nxt = ST_EMIT_RD;
        end
      end
      ST_EMIT_RD:   st_nxt = ST_EMIT_LD;
      ST_EMIT_LD:   st_nxt = ST_EMIT_HOLD;
      ST_EMIT_HOLD: begin
        if (out_tready) begin
          st_nxt = (k_r == IDX_LAST) ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default:      st_nxt = ST_IDLE;
    endcase
  end

  // Outputs and memory controls.
  always_comb begin
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    w_rd_en    = 1'b0;
    s_rd_en    = 1'b0;
    s_rd_rgn   = src_rgn;
    s_rd_idx   = i_r;
    ctl_nxt    = '0;
    unique case (st_r)
      ST_IDLE:      in_tready = 1'b1;
      ST_STEP: begin
        w_rd_en       = 1'b1;
        s_rd_en       = 1'b1;
        ctl_nxt.vld   = 1'b1;
        ctl_nxt.first = (i_r == '0);
        ctl_nxt.last  = (i_r == IDX_LAST);
      end
      ST_EMIT_RD: begin
        s_rd_en  = 1'b1;
        s_rd_rgn = fin_rgn_r;
        s_rd_idx = k_r;
      end
      ST_EMIT_LD:   ;
      ST_EMIT_HOLD: out_tvalid = 1'b1;
      default:      ;
    endcase
  end

  assign w_rd_addr = {i_r, j_r};
  assign w_wr_en   = in_acc && (in_mode == MODE_WEIGHT) && row_ok && col_ok;
  assign w_wr_addr = {in_row[IDX_W-1:0], in_col[IDX_W-1:0]};
  assign w_wr_data = in_tdata[WEIGHT_LSB +: WEIGHT_W];

  // Column results and initial-state writes never fall in the same cycle.
  always_comb begin
    if (mac_res_vld) begin
      s_wr_en   = 1'b1;
      s_wr_rgn  = dest_d_r;
      s_wr_idx  = j_d_r;
      s_wr_data = mac_res_trit;
    end else begin
      s_wr_en   = in_acc && (in_mode == MODE_INIT) && row_ok;
      s_wr_rgn  = RGN_INIT;
      s_wr_idx  = in_row[IDX_W-1:0];
      s_wr_data = trit_sat(in_tdata[INIT_LSB +: TRIT_W]);
    end
  end

  // Counters.
  always_comb begin
    step_nxt    = step_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    k_nxt       = k_r;
    fin_rgn_nxt = fin_rgn_r;
    case (st_r)
      ST_IDLE: begin
        step_nxt    = '0;
        i_nxt       = '0;
        j_nxt       = '0;
        k_nxt       = '0;
        fin_rgn_nxt = RGN_INIT;
      end
      ST_STEP: begin
        i_nxt = (i_r == IDX_LAST) ? '0 : i_r + 1'b1;
        if (i_r == IDX_LAST) begin
          j_nxt = (j_r == IDX_LAST) ? '0 : j_r + 1'b1;
        end
        if (step_done) begin
          if (last_step) begin
            fin_rgn_nxt = dest_rgn;
          end else begin
            step_nxt = step_r + 1'b1;
          end
        end
      end
      ST_EMIT_HOLD: begin
        if (out_tready && (k_r != IDX_LAST)) begin
          k_nxt = k_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_IDLE;
      step_cnt_r <= STEP_RESET;
      step_r     <= '0;
      i_r        <= '0;
      j_r        <= '0;
      k_r        <= '0;
      fin_rgn_r  <= RGN_INIT;
      ctl_r      <= '0;
    end else begin
      st_r      <= st_nxt;
      step_r    <= step_nxt;
      i_r       <= i_nxt;
      j_r       <= j_nxt;
      k_r       <= k_nxt;
      fin_rgn_r <= fin_rgn_nxt;
      ctl_r     <= ctl_nxt;
      if (cfg_wr_en) begin
        step_cnt_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    j_d_r    <= j_r;
    dest_d_r <= dest_rgn;
    if (st_r == ST_EMIT_LD) begin
      out_trit_r <= s_rd_data;
    end
  end

  assign mac_ctl   = ctl_r;
  assign out_tdata = {out_trit_r, GENE_W'(k_r)};
  assign out_tlast = (k_r == IDX_LAST);

endmodule

`default_nettype wire

// ===== hdl/stni_chk.sv =====
// Port-level checker for the sign-threshold network iteration block and its
// bind to the top level. Depends on stni_pkg.
`default_nettype none

module stni_chk
  import stni_pkg::*;
#(
  parameter int GENES = 16
) (
  input wire              clk,
  input wire              rst_n,
  input wire              in_tready,
  input wire              out_tvalid,
  input wire              out_tready,
  input wire [OUT_W-1:0]  out_tdata,
  input wire              out_tlast
);

  localparam logic [GENE_W-1:0] GENE_LAST = GENE_W'(GENES - 1);

  // Inputs are not taken while a run is emitting results.
  a_no_input_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input ready while a result beat is pending");

  a_last_is_top_gene: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tdata[GENE_W-1:0] == GENE_LAST)))
    else $error("tlast does not match the final gene index");

  a_trit_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[OUT_W-1:GENE_W] != 2'b10))
    else $error("final_value carries an illegal pattern");

  // The run ends with its last beat; the block is back to taking inputs.
  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> !out_tvalid && in_tready)
    else $error("block did not return to idle after the last beat");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result beat changed");

endmodule

bind sign_threshold_network_iteration stni_chk #(.GENES(GENES)) u_stni_chk (.*);

`default_nettype wire
